### design/gtes_pkg.sv
package gtes_pkg;

    localparam int SLOT_W   = 10;
    localparam int VALUE_W  = 64;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 11;
    localparam int GEN_W    = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET        = 3'd0,
        MODE_GET        = 3'd1,
        MODE_INVALIDATE = 3'd2,
        MODE_NEXT       = 3'd3,
        MODE_COLLECT    = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOT_SET  = 2'd1,
        ST_BAD_SLOT = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // one result word as it sits in the output register
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value;
        logic               is_valid;
        status_t            status;
        logic               last_entry;
    } result_t;

endpackage

### design/gtes_ram.sv
module gtes_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/generation_tagged_event_store.sv
// generation tagged event store
// in channel (in_valid / in_ready) takes one command word: mode, slot, value.
// out channel (out_valid / out_ready) returns exactly one result word per command.
// cfg channel (cfg_valid / cfg_ready) writes slots_in_use; always ready, write only
// while no command is in flight.
// steps per command, from accept to the next accept:
//   set, get, next event, unused modes: tag and value memory read, then update
//   collect: scoreboard list read, then value memory read at that entry,
//   or no value read when nothing is left to collect
//   invalidate of a live slot: tag retired, then list compaction walks the list
//   memory, one entry per cycle, read and shifted write overlapped
// the result word appears in the same cycle in which in_ready returns high.
// after reset the tag memory is swept to zero, one slot a cycle over every slot;
// in_ready stays low during the sweep, configuration writes are still taken.
// a stalled receiver holds the result in the output register; a new command is
// still accepted and runs up to its result, where it waits for the register
// to drain before committing.
module generation_tagged_event_store #(
    parameter int SLOTS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gtes_pkg::LIMIT_W-1:0]    cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [gtes_pkg::MODE_W-1:0]     mode,
    input  logic [gtes_pkg::SLOT_W-1:0]     slot,
    input  logic [gtes_pkg::VALUE_W-1:0]    value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [gtes_pkg::SLOT_W-1:0]     out_slot,
    output logic [gtes_pkg::VALUE_W-1:0]    out_value,
    output logic                            is_valid,
    output logic [gtes_pkg::STATUS_W-1:0]   status,
    output logic                            last_entry
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int XW = AW + gtes_pkg::SLOT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_COLL,
        S_WALK,
        S_DONE
    } state_t;

    // control state
    state_t                         state_reg, state_next;
    logic [gtes_pkg::LIMIT_W-1:0]   limit_reg, limit_next;
    logic [gtes_pkg::GEN_W-1:0]     gen_reg, gen_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  cursor_reg, cursor_next;
    logic [AW-1:0]                  clr_idx_reg, clr_idx_next;
    logic                           found_reg, found_next;
    logic                           out_valid_reg, out_valid_next;

    // payload
    logic [gtes_pkg::MODE_W-1:0]    mode_reg, mode_next;
    logic [gtes_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic [gtes_pkg::VALUE_W-1:0]   value_reg, value_next;
    logic [CW-1:0]                  walk_idx_reg, walk_idx_next;
    logic [CW-1:0]                  pos_reg, pos_next;
    gtes_pkg::result_t              res_reg, res_next;

    // memory ports
    logic                           val_we, val_re;
    logic [AW-1:0]                  val_waddr, val_raddr;
    logic [gtes_pkg::VALUE_W-1:0]   val_wdata, val_rdata;
    logic                           tag_we, tag_re;
    logic [AW-1:0]                  tag_waddr, tag_raddr;
    logic [gtes_pkg::GEN_W-1:0]     tag_wdata, tag_rdata;
    logic                           lst_we, lst_re;
    logic [AW-1:0]                  lst_waddr, lst_raddr;
    logic [gtes_pkg::SLOT_W-1:0]    lst_wdata, lst_rdata;

    logic                           out_free;
    logic                           tag_live;
    logic                           slot_mode;
    logic                           slot_in_range;
    logic [CW-1:0]                  count_inc, cursor_inc, walk_inc, walk_prev;

    // slot number to memory address, zero extended or truncated to the depth
    function automatic logic [AW-1:0] to_addr(input logic [gtes_pkg::SLOT_W-1:0] s);
        logic [XW-1:0] x;
        x = XW'(s);
        return x[AW-1:0];
    endfunction

    // value bits per slot
    gtes_ram #(.DEPTH(SLOTS), .WIDTH(gtes_pkg::VALUE_W)) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .re    (val_re),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    // generation tag per slot, live when equal to the current generation
    gtes_ram #(.DEPTH(SLOTS), .WIDTH(gtes_pkg::GEN_W)) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (tag_re),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    // ordered scoreboard of slots set in this event
    gtes_ram #(.DEPTH(SLOTS), .WIDTH(gtes_pkg::SLOT_W)) u_list_ram (
        .clk   (clk),
        .we    (lst_we),
        .waddr (lst_waddr),
        .wdata (lst_wdata),
        .re    (lst_re),
        .raddr (lst_raddr),
        .rdata (lst_rdata)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);

    // output register can take a word this cycle
    assign out_free = !out_valid_reg || out_ready;

    assign tag_live      = (tag_rdata == gen_reg);
    assign slot_mode     = (mode_reg == gtes_pkg::MODE_SET)
                        || (mode_reg == gtes_pkg::MODE_GET)
                        || (mode_reg == gtes_pkg::MODE_INVALIDATE);
    assign slot_in_range = (int'(slot_reg) < int'(limit_reg)) && (int'(slot_reg) < SLOTS);

    assign count_inc  = count_reg + CW'(1);
    assign cursor_inc = cursor_reg + CW'(1);
    assign walk_inc   = walk_idx_reg + CW'(1);
    assign walk_prev  = walk_idx_reg - CW'(1);

    always_comb
    begin
        state_next     = state_reg;
        limit_next     = cfg_valid ? cfg_data : limit_reg;
        gen_next       = gen_reg;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        clr_idx_next   = clr_idx_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mode_next      = mode_reg;
        slot_next      = slot_reg;
        value_next     = value_reg;
        walk_idx_next  = walk_idx_reg;
        pos_next       = pos_reg;
        res_next       = res_reg;

        val_we    = 1'b0;
        val_waddr = to_addr(slot_reg);
        val_wdata = value_reg;
        val_re    = 1'b0;
        val_raddr = to_addr(slot);
        tag_we    = 1'b0;
        tag_waddr = to_addr(slot_reg);
        tag_wdata = gen_reg;
        tag_re    = 1'b0;
        tag_raddr = to_addr(slot);
        lst_we    = 1'b0;
        lst_waddr = count_reg[AW-1:0];
        lst_wdata = slot_reg;
        lst_re    = 1'b0;
        lst_raddr = cursor_reg[AW-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                // zero the tags so no slot looks live in the first event
                tag_we    = 1'b1;
                tag_waddr = clr_idx_reg;
                tag_wdata = '0;
                if (clr_idx_reg == AW'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    slot_next  = slot;
                    value_next = value;
                    // speculative reads; only the ones the mode needs are used
                    tag_re     = 1'b1;
                    val_re     = 1'b1;
                    lst_re     = 1'b1;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (slot_mode && !slot_in_range)
                begin
                    if (out_free)
                    begin
                        res_next       = '0;
                        res_next.slot  = slot_reg;
                        res_next.status = gtes_pkg::ST_BAD_SLOT;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    case (mode_reg)
                        gtes_pkg::MODE_SET:
                        begin
                            if (out_free)
                            begin
                                val_we = 1'b1;
                                if (!tag_live)
                                begin
                                    // first set this event: tag it and append
                                    tag_we = 1'b1;
                                    if (int'(count_reg) < SLOTS)
                                    begin
                                        lst_we     = 1'b1;
                                        count_next = count_inc;
                                    end
                                end
                                res_next          = '0;
                                res_next.slot     = slot_reg;
                                res_next.value    = value_reg;
                                res_next.is_valid = 1'b1;
                                res_next.status   = gtes_pkg::ST_OK;
                                out_valid_next    = 1'b1;
                                state_next        = S_IDLE;
                            end
                        end

                        gtes_pkg::MODE_GET:
                        begin
                            if (out_free)
                            begin
                                res_next      = '0;
                                res_next.slot = slot_reg;
                                if (tag_live)
                                begin
                                    res_next.value    = val_rdata;
                                    res_next.is_valid = 1'b1;
                                    res_next.status   = gtes_pkg::ST_OK;
                                end
                                else
                                begin
                                    res_next.status = gtes_pkg::ST_NOT_SET;
                                end
                                out_valid_next = 1'b1;
                                state_next     = S_IDLE;
                            end
                        end

                        gtes_pkg::MODE_INVALIDATE:
                        begin
                            if (!tag_live)
                            begin
                                if (out_free)
                                begin
                                    res_next        = '0;
                                    res_next.slot   = slot_reg;
                                    res_next.status = gtes_pkg::ST_NOT_SET;
                                    out_valid_next  = 1'b1;
                                    state_next      = S_IDLE;
                                end
                            end
                            else
                            begin
                                // retire the tag, then search and compact the list
                                tag_we        = 1'b1;
                                tag_wdata     = gen_reg - gtes_pkg::GEN_W'(1);
                                found_next    = 1'b0;
                                walk_idx_next = '0;
                                if (count_reg == '0)
                                begin
                                    state_next = S_DONE;
                                end
                                else
                                begin
                                    lst_re     = 1'b1;
                                    lst_raddr  = '0;
                                    state_next = S_WALK;
                                end
                            end
                        end

                        gtes_pkg::MODE_NEXT:
                        begin
                            if (out_free)
                            begin
                                gen_next       = gen_reg + gtes_pkg::GEN_W'(1);
                                count_next     = '0;
                                cursor_next    = '0;
                                res_next       = '0;
                                out_valid_next = 1'b1;
                                state_next     = S_IDLE;
                            end
                        end

                        gtes_pkg::MODE_COLLECT:
                        begin
                            if (cursor_reg < count_reg)
                            begin
                                // list entry is here, fetch its value
                                val_re     = 1'b1;
                                val_raddr  = to_addr(lst_rdata);
                                state_next = S_COLL;
                            end
                            else if (out_free)
                            begin
                                res_next        = '0;
                                res_next.status = gtes_pkg::ST_EMPTY;
                                out_valid_next  = 1'b1;
                                state_next      = S_IDLE;
                            end
                        end

                        default:
                        begin
                            if (out_free)
                            begin
                                res_next       = '0;
                                out_valid_next = 1'b1;
                                state_next     = S_IDLE;
                            end
                        end
                    endcase
                end
            end

            S_COLL:
            begin
                if (out_free)
                begin
                    res_next            = '0;
                    res_next.slot       = lst_rdata;
                    res_next.value      = val_rdata;
                    res_next.is_valid   = 1'b1;
                    res_next.status     = gtes_pkg::ST_OK;
                    res_next.last_entry = (cursor_inc == count_reg);
                    cursor_next         = cursor_inc;
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            S_WALK:
            begin
                // lst_rdata holds entry walk_idx; past the match shift it down one
                if (found_reg)
                begin
                    lst_we    = 1'b1;
                    lst_waddr = walk_prev[AW-1:0];
                    lst_wdata = lst_rdata;
                end
                else if (lst_rdata == slot_reg)
                begin
                    found_next = 1'b1;
                    pos_next   = walk_idx_reg;
                end
                if (walk_inc < count_reg)
                begin
                    lst_re        = 1'b1;
                    lst_raddr     = walk_inc[AW-1:0];
                    walk_idx_next = walk_inc;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    if (found_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        // an entry behind the cursor went away, step back
                        if (pos_reg < cursor_reg)
                        begin
                            cursor_next = cursor_reg - CW'(1);
                        end
                    end
                    res_next        = '0;
                    res_next.slot   = slot_reg;
                    res_next.status = gtes_pkg::ST_OK;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            limit_reg     <= '0;
            gen_reg       <= gtes_pkg::GEN_W'(1);
            count_reg     <= '0;
            cursor_reg    <= '0;
            clr_idx_reg   <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            gen_reg       <= gen_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            clr_idx_reg   <= clr_idx_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // captured command and result word, no reset needed
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        slot_reg     <= slot_next;
        value_reg    <= value_next;
        walk_idx_reg <= walk_idx_next;
        pos_reg      <= pos_next;
        res_reg      <= res_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_slot   = res_reg.slot;
    assign out_value  = res_reg.value;
    assign is_valid   = res_reg.is_valid;
    assign status     = res_reg.status;
    assign last_entry = res_reg.last_entry;

    // collect cursor never runs past the list
    a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= count_reg)
        else $error("collect cursor beyond scoreboard count");

    a_count_in_depth: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= SLOTS)
        else $error("scoreboard count beyond depth");

    // one command at a time until its result is committed
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("command accepted while another is in flight");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_EXEC)
                              || ($past(state_reg) == S_COLL)
                              || ($past(state_reg) == S_DONE))
        else $error("result word raised outside a commit state");

    a_last_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_entry |-> is_valid && (status == gtes_pkg::ST_OK))
        else $error("last entry mark on a failed result");

endmodule

### tb/generation_tagged_event_store_tb.sv
`timescale 1ns / 100ps

module generation_tagged_event_store_tb;

    localparam int SLOTS        = 1024;
    localparam int QUIET_LIMIT  = 6000;   // cycles with no handshake at all
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
    localparam int TAIL_CYCLES  = 20;
    localparam int PHASE_WORDS  = 135;

    // modes the block does not define, answered with an all-zero word
    localparam logic [gtes_pkg::MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [gtes_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [gtes_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    logic                               clk;
    logic                               rst_n     = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [gtes_pkg::LIMIT_W-1:0]       cfg_data  = '0;
    logic                               in_valid  = 1'b0;
    logic                               in_ready;
    logic [gtes_pkg::MODE_W-1:0]        mode      = '0;
    logic [gtes_pkg::SLOT_W-1:0]        slot      = '0;
    logic [gtes_pkg::VALUE_W-1:0]       value     = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [gtes_pkg::SLOT_W-1:0]        out_slot;
    logic [gtes_pkg::VALUE_W-1:0]       out_value;
    logic                               is_valid;
    logic [gtes_pkg::STATUS_W-1:0]      status;
    logic                               last_entry;

    generation_tagged_event_store #(
        .SLOTS(SLOTS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .slot       (slot),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_slot   (out_slot),
        .out_value  (out_value),
        .is_valid   (is_valid),
        .status     (status),
        .last_entry (last_entry)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // shadow copy of the store, stepped once per accepted command word
    logic [gtes_pkg::VALUE_W-1:0]   shadow_value [SLOTS];
    logic [gtes_pkg::GEN_W-1:0]     shadow_tag [SLOTS];
    logic [gtes_pkg::GEN_W-1:0]     generation;
    logic [gtes_pkg::SLOT_W-1:0]    event_list [SLOTS];
    int                             list_len;
    int                             collect_pos;
    logic [gtes_pkg::LIMIT_W-1:0]   slot_limit;

    // result words still owed by the block, oldest first
    gtes_pkg::result_t              awaited_words [$];

    int                             errors;
    int                             words_sent;
    int                             send_gap_pct;
    int                             recv_idle_pct;
    int                             stall_order;

    // one row of the directed table: either a limit write or a command word
    typedef struct packed {
        logic                           is_cfg;
        logic [gtes_pkg::LIMIT_W-1:0]   cfg;
        logic [gtes_pkg::MODE_W-1:0]    m;
        logic [gtes_pkg::SLOT_W-1:0]    s;
        logic [gtes_pkg::VALUE_W-1:0]   v;
        logic                           typed;
        gtes_pkg::result_t              want;
    } plan_row_t;

    plan_row_t directed_plan [$];

    function automatic gtes_pkg::result_t pack_word(
        input logic [gtes_pkg::SLOT_W-1:0] s,
        input logic [gtes_pkg::VALUE_W-1:0] v,
        input logic ok, input gtes_pkg::status_t st,
        input logic last);
        gtes_pkg::result_t w;
        w.slot       = s;
        w.value      = v;
        w.is_valid   = ok;
        w.status     = st;
        w.last_entry = last;
        return w;
    endfunction

    // expected answer of the store to one command word, advancing the shadow state
    function automatic gtes_pkg::result_t store_step(
        input logic [gtes_pkg::MODE_W-1:0] m,
        input logic [gtes_pkg::SLOT_W-1:0] s,
        input logic [gtes_pkg::VALUE_W-1:0] v);
        gtes_pkg::result_t              r;
        int                             lim;
        int                             hit;
        int                             i;
        logic                           live;
        logic [gtes_pkg::SLOT_W-1:0]    e;
        r    = '0;
        lim  = (slot_limit > gtes_pkg::LIMIT_W'(SLOTS)) ? SLOTS : int'(slot_limit);
        live = (shadow_tag[s] == generation);
        case (m) inside
            gtes_pkg::MODE_SET, gtes_pkg::MODE_GET, gtes_pkg::MODE_INVALIDATE:
            begin
                if (int'(s) >= lim)
                begin
                    r = pack_word(s, '0, 1'b0, gtes_pkg::ST_BAD_SLOT, 1'b0);
                end
                else if (m == gtes_pkg::MODE_SET)
                begin
                    shadow_value[s] = v;
                    // first write this event joins the scoreboard list
                    if (!live)
                    begin
                        shadow_tag[s] = generation;
                        if (list_len < SLOTS)
                        begin
                            event_list[list_len] = s;
                            list_len++;
                        end
                    end
                    r = pack_word(s, v, 1'b1, gtes_pkg::ST_OK, 1'b0);
                end
                else if (m == gtes_pkg::MODE_GET)
                begin
                    if (live)
                        r = pack_word(s, shadow_value[s], 1'b1, gtes_pkg::ST_OK, 1'b0);
                    else
                        r = pack_word(s, '0, 1'b0, gtes_pkg::ST_NOT_SET, 1'b0);
                end
                else if (!live)
                begin
                    r = pack_word(s, '0, 1'b0, gtes_pkg::ST_NOT_SET, 1'b0);
                end
                else
                begin
                    // drop the entry, close the gap, keep the collect position honest
                    hit = -1;
                    for (i = 0; i < list_len; i++)
                        if (hit < 0 && event_list[i] == s)
                            hit = i;
                    if (hit >= 0)
                    begin
                        for (i = hit; i < list_len - 1; i++)
                            event_list[i] = event_list[i + 1];
                        list_len--;
                        if (hit < collect_pos)
                            collect_pos--;
                    end
                    shadow_tag[s] = generation - gtes_pkg::GEN_W'(1);
                    r = pack_word(s, '0, 1'b0, gtes_pkg::ST_OK, 1'b0);
                end
            end
            gtes_pkg::MODE_NEXT:
            begin
                generation  = generation + gtes_pkg::GEN_W'(1);
                list_len    = 0;
                collect_pos = 0;
            end
            gtes_pkg::MODE_COLLECT:
            begin
                if (collect_pos < list_len)
                begin
                    e = event_list[collect_pos];
                    collect_pos++;
                    r = pack_word(e, shadow_value[e], 1'b1, gtes_pkg::ST_OK,
                                  collect_pos == list_len);
                end
                else
                begin
                    r = pack_word('0, '0, 1'b0, gtes_pkg::ST_EMPTY, 1'b0);
                end
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    // offer one command word; valid stays up into the next word when there is no gap
    task automatic send_word(input logic [gtes_pkg::MODE_W-1:0] m,
                             input logic [gtes_pkg::SLOT_W-1:0] s,
                             input logic [gtes_pkg::VALUE_W-1:0] v,
                             input logic typed = 1'b0,
                             input gtes_pkg::result_t typed_word = '0);
        gtes_pkg::result_t predicted;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        slot     <= s;
        value    <= v;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        predicted = store_step(m, s, v);
        awaited_words.insert(awaited_words.size(), typed ? typed_word : predicted);
        words_sent++;
    endtask

    // drop valid and let every owed result word come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [gtes_pkg::LIMIT_W-1:0] n);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        slot_limit = n;
    endtask

    task automatic plan_cmd(input logic [gtes_pkg::MODE_W-1:0] m,
                            input logic [gtes_pkg::SLOT_W-1:0] s,
                            input logic [gtes_pkg::VALUE_W-1:0] v,
                            input logic typed = 1'b0,
                            input gtes_pkg::result_t want = '0);
        plan_row_t row;
        row        = '0;
        row.m      = m;
        row.s      = s;
        row.v      = v;
        row.typed  = typed;
        row.want   = want;
        directed_plan.insert(directed_plan.size(), row);
    endtask

    task automatic plan_cfg(input logic [gtes_pkg::LIMIT_W-1:0] n);
        plan_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.cfg    = n;
        directed_plan.insert(directed_plan.size(), row);
    endtask

    // mostly slots already set this event or inside the limit, a few anywhere
    function automatic logic [gtes_pkg::SLOT_W-1:0] pick_slot(input int lim);
        int r;
        r = $urandom_range(99);
        if (r < 35 && list_len > 0)
            return event_list[$urandom_range(list_len - 1)];
        if (r < 90 && lim > 0)
            return gtes_pkg::SLOT_W'($urandom_range(lim - 1));
        return gtes_pkg::SLOT_W'($urandom_range(SLOTS - 1));
    endfunction

    // one event: random sets, gets, invalidates, collects and spare modes, then drain the scoreboard and move on
    task automatic random_event();
        int r;
        int lim;
        lim = (slot_limit > gtes_pkg::LIMIT_W'(SLOTS)) ? SLOTS : int'(slot_limit);
        // now and then a burst of raw noise, spare modes included
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 4))
                send_word(gtes_pkg::MODE_W'($urandom_range(7)),
                          gtes_pkg::SLOT_W'($urandom_range(SLOTS - 1)),
                          {$urandom, $urandom});
            return;
        end
        repeat ($urandom_range(3, 20))
        begin
            r = $urandom_range(99);
            if (r < 45)
                send_word(gtes_pkg::MODE_SET, pick_slot(lim), {$urandom, $urandom});
            else if (r < 65)
                send_word(gtes_pkg::MODE_GET, pick_slot(lim), {$urandom, $urandom});
            else if (r < 77)
                send_word(gtes_pkg::MODE_INVALIDATE, pick_slot(lim),
                          {$urandom, $urandom});
            else if (r < 94)
                send_word(gtes_pkg::MODE_COLLECT, gtes_pkg::SLOT_W'($urandom),
                          {$urandom, $urandom});
            else
                send_word(gtes_pkg::MODE_W'($urandom_range(5, 7)),
                          gtes_pkg::SLOT_W'($urandom), {$urandom, $urandom});
        end
        // walk the rest of the scoreboard, one past its end, then next event
        while (collect_pos < list_len)
            send_word(gtes_pkg::MODE_COLLECT, gtes_pkg::SLOT_W'($urandom),
                      {$urandom, $urandom});
        send_word(gtes_pkg::MODE_COLLECT, gtes_pkg::SLOT_W'($urandom),
                  {$urandom, $urandom});
        send_word(gtes_pkg::MODE_NEXT, gtes_pkg::SLOT_W'($urandom),
                  {$urandom, $urandom});
    endtask

    task automatic report_mismatch(input string field,
                                   input logic [gtes_pkg::VALUE_W-1:0] want,
                                   input logic [gtes_pkg::VALUE_W-1:0] got);
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    endtask

    // result word checker, field by field against the oldest owed word
    always @(posedge clk)
    begin
        gtes_pkg::result_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (awaited_words.size() == 0)
            begin
                report_mismatch("unexpected word, out_slot", '0, out_slot);
            end
            else
            begin
                want = awaited_words.pop_front();
                if (want.slot !== out_slot)
                    report_mismatch("out_slot", want.slot, out_slot);
                if (want.value !== out_value)
                    report_mismatch("out_value", want.value, out_value);
                if (want.is_valid !== is_valid)
                    report_mismatch("is_valid", want.is_valid, is_valid);
                if (want.status !== status)
                    report_mismatch("status", want.status, status);
                if (want.last_entry !== last_entry)
                    report_mismatch("last_entry", want.last_entry, last_entry);
            end
        end
    end

    // receiver: random idling, plus a long hold-off whenever one is ordered
    initial
    begin : receiver
        int hold_left;
        int seen;
        hold_left = 0;
        seen      = 0;
        forever
        begin
            @(posedge clk);
            if (stall_order != seen)
            begin
                seen      = stall_order;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog: too long without any word moving on any channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)
                || (cfg_valid && cfg_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        int p;
        int phase_start;
        logic [gtes_pkg::LIMIT_W-1:0] phase_limit;

        for (i = 0; i < SLOTS; i++)
        begin
            shadow_value[i] = '0;
            shadow_tag[i]   = '0;
            event_list[i]   = '0;
        end
        generation    = gtes_pkg::GEN_W'(1);
        list_len      = 0;
        collect_pos   = 0;
        slot_limit    = '0;
        errors        = 0;
        words_sent    = 0;
        stall_order   = 0;
        send_gap_pct  = 8;
        recv_idle_pct = 73;

        // with the limit still at its reset value of zero every slot is bad
        plan_cmd(gtes_pkg::MODE_SET, 10'd0, 64'hDEAD_BEEF_0000_0001, 1'b1,
                 pack_word(10'd0, '0, 1'b0, gtes_pkg::ST_BAD_SLOT, 1'b0));
        plan_cmd(gtes_pkg::MODE_GET, 10'd1023, 64'h0, 1'b1,
                 pack_word(10'd1023, '0, 1'b0, gtes_pkg::ST_BAD_SLOT, 1'b0));
        plan_cmd(gtes_pkg::MODE_COLLECT, 10'd0, 64'h0, 1'b1,
                 pack_word('0, '0, 1'b0, gtes_pkg::ST_EMPTY, 1'b0));
        plan_cfg(11'd1024);
        plan_cmd(gtes_pkg::MODE_GET, 10'd5, 64'h0, 1'b1,
                 pack_word(10'd5, '0, 1'b0, gtes_pkg::ST_NOT_SET, 1'b0));
        plan_cmd(gtes_pkg::MODE_SET, 10'd0, '1, 1'b1,
                 pack_word(10'd0, '1, 1'b1, gtes_pkg::ST_OK, 1'b0));
        plan_cmd(gtes_pkg::MODE_SET, 10'd1023, 64'h0, 1'b1,
                 pack_word(10'd1023, '0, 1'b1, gtes_pkg::ST_OK, 1'b0));
        plan_cmd(gtes_pkg::MODE_SET, 10'd512, 64'hA5A5_A5A5_A5A5_A5A5);
        // rewrite in the same event: value changes, list does not grow
        plan_cmd(gtes_pkg::MODE_SET, 10'd0, 64'h5A5A_5A5A_5A5A_5A5A);
        plan_cmd(gtes_pkg::MODE_GET, 10'd0, 64'h0);
        plan_cmd(gtes_pkg::MODE_INVALIDATE, 10'd777, 64'h0, 1'b1,
                 pack_word(10'd777, '0, 1'b0, gtes_pkg::ST_NOT_SET, 1'b0));
        plan_cmd(gtes_pkg::MODE_COLLECT, 10'd0, 64'h0);
        // entry behind the collect position: position steps back, nothing skipped
        plan_cmd(gtes_pkg::MODE_INVALIDATE, 10'd0, 64'h0);
        plan_cmd(gtes_pkg::MODE_COLLECT, 10'd0, 64'h0);
        plan_cmd(gtes_pkg::MODE_COLLECT, 10'd0, 64'h0);
        plan_cmd(gtes_pkg::MODE_COLLECT, 10'd0, 64'h0, 1'b1,
                 pack_word('0, '0, 1'b0, gtes_pkg::ST_EMPTY, 1'b0));
        plan_cmd(gtes_pkg::MODE_GET, 10'd0, 64'h0, 1'b1,
                 pack_word(10'd0, '0, 1'b0, gtes_pkg::ST_NOT_SET, 1'b0));
        plan_cmd(MODE_SPARE_5, 10'd1023, '1, 1'b1, '0);
        plan_cmd(MODE_SPARE_7, 10'd512, '1, 1'b1, '0);
        plan_cmd(gtes_pkg::MODE_NEXT, 10'd0, 64'h0, 1'b1, '0);
        // next event clears every slot at once
        plan_cmd(gtes_pkg::MODE_GET, 10'd1023, 64'h0, 1'b1,
                 pack_word(10'd1023, '0, 1'b0, gtes_pkg::ST_NOT_SET, 1'b0));
        plan_cmd(gtes_pkg::MODE_SET, 10'd1023, 64'h1);
        // limit shrinks under a live entry
        plan_cfg(11'd1);
        plan_cmd(gtes_pkg::MODE_SET, 10'd1, 64'h1, 1'b1,
                 pack_word(10'd1, '0, 1'b0, gtes_pkg::ST_BAD_SLOT, 1'b0));
        plan_cmd(gtes_pkg::MODE_INVALIDATE, 10'd1023, 64'h0, 1'b1,
                 pack_word(10'd1023, '0, 1'b0, gtes_pkg::ST_BAD_SLOT, 1'b0));
        plan_cmd(gtes_pkg::MODE_SET, 10'd0, 64'h8000_0000_0000_0000);
        plan_cmd(gtes_pkg::MODE_COLLECT, 10'd0, 64'h0);
        plan_cmd(gtes_pkg::MODE_COLLECT, 10'd0, 64'h0);
        plan_cmd(gtes_pkg::MODE_COLLECT, 10'd0, 64'h0, 1'b1,
                 pack_word('0, '0, 1'b0, gtes_pkg::ST_EMPTY, 1'b0));
        plan_cmd(MODE_SPARE_6, 10'd1023, '1, 1'b1, '0);

        // reset once; the block then sweeps its tag memory with in_ready low
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < directed_plan.size(); i++)
        begin
            if (directed_plan[i].is_cfg)
            begin
                wait_drained();
                write_limit(directed_plan[i].cfg);
            end
            else
            begin
                send_word(directed_plan[i].m, directed_plan[i].s, directed_plan[i].v,
                          directed_plan[i].typed, directed_plan[i].want);
            end
        end

        // random phases: receiver idles mostly, then the sender does, then neither
        for (p = 0; p < 3; p++)
        begin
            wait_drained();
            case (p)
                0:
                begin
                    send_gap_pct  = 8;
                    recv_idle_pct = 73;
                    phase_limit   = 11'd37;
                end
                1:
                begin
                    send_gap_pct  = 73;
                    recv_idle_pct = 8;
                    phase_limit   = 11'd2047;
                end
                default:
                begin
                    send_gap_pct  = 0;
                    recv_idle_pct = 0;
                    phase_limit   = 11'd1024;
                end
            endcase
            write_limit(phase_limit);
            // back pressure: receiver holds off while words keep coming
            if (p == 2)
                stall_order++;
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS)
                random_event();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && awaited_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
